[hw/rtl/sed_pkg.sv]
// Shared widths, limits and codes of the speech endpoint detector.
package sed_pkg;

  localparam int COUNT_BITS   = 21;
  localparam int LEVEL_BITS   = 16;
  localparam int BLOCK_BITS   = 13;
  localparam int RATE_BITS    = 18;
  localparam int MAX_BLOCK    = 4096;
  localparam int CFG_IDX_BITS = 3;
  localparam int THR_BITS     = 7;
  localparam int SIL_FLOOR    = 20;
  localparam int SIL_CEIL     = 90;
  localparam int DIV_CNT_BITS = $clog2(COUNT_BITS);
  localparam int OUTCOME_BITS = 3;
  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 80;

  typedef enum logic [OUTCOME_BITS-1:0] {
    OUT_CONTINUE   = 3'd0,
    OUT_CAPTURED   = 3'd1,
    OUT_NO_SPEECH  = 3'd2,
    OUT_READ_ERROR = 3'd3,
    OUT_IDLE       = 3'd4
  } outcome_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CAP_LIMIT       = 3'd0,
    CFG_START_TIMEOUT   = 3'd1,
    CFG_CONFIRM_SAMPLES = 3'd2,
    CFG_SILENCE_SAMPLES = 3'd3,
    CFG_PREROLL_SAMPLES = 3'd4,
    CFG_RATE_HZ         = 3'd5,
    CFG_START_LEVEL     = 3'd6,
    CFG_SILENCE_MARGIN  = 3'd7
  } cfg_idx_e;

endpackage

[hw/rtl/sed_div.sv]
// Radix-2 restoring divider that turns the captured count into whole seconds.
module sed_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [sed_pkg::COUNT_BITS-1:0]    dividend_i,
  input  logic [sed_pkg::RATE_BITS-1:0]     divisor_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [sed_pkg::COUNT_BITS-1:0]    quotient_o
);
  import sed_pkg::*;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]   quo_q, quo_d;
  logic [RATE_BITS-1:0]    rem_q, rem_d;
  logic [RATE_BITS-1:0]    dvs_q, dvs_d;
  logic [RATE_BITS:0]      rem_sh;
  logic [RATE_BITS:0]      rem_diff;
  logic                    fits;

  // One quotient bit per cycle: shift in the next dividend bit, try the subtract.
  assign rem_sh   = {rem_q, quo_q[COUNT_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_q};
  assign fits     = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      // A rate of zero divides as one.
      dvs_d  = (divisor_i == '0) ? RATE_BITS'(1) : divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_diff[RATE_BITS-1:0] : rem_sh[RATE_BITS-1:0];
      quo_d = {quo_q[COUNT_BITS-2:0], fits};
      cnt_d = cnt_q + DIV_CNT_BITS'(1);
      if (cnt_q == DIV_CNT_BITS'(COUNT_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[hw/rtl/speech_endpoint_detector.sv]
// Top level of the energy-based speech endpoint detector.
// The detector takes one summary beat per audio block and answers each with
// exactly one result beat. A beat with tuser set opens a new session and
// clears all session state; audio beats then update the captured count, an
// attack-fast release-slow smoothed level, the lowest idle mean level and the
// voiced and silent run lengths, and report either "continue" or how the
// session ended (speech captured, no speech, read error). On a capture the
// result also carries the first kept sample, which keeps the configured
// pre-roll ahead of the detected speech start, and the kept sample count.
// The elapsed whole seconds come from a shared one-bit-per-cycle divider, and
// a progress flag marks each change of that figure. An audio beat in an
// active session passes from acceptance to the result register through
// 6 sequencer steps (count saturation, accumulate, run clamp, decision, trim
// and payload), the divider start, the divider iterations (one per count
// bit), the step in which the sequencer sees the divider finish and the step
// that loads the result. A read error or an empty block goes from the
// saturation step straight to the divider, a start timeout skips the trim
// and payload steps, and a session already at its limit skips the analysis.
// A begin beat, or an audio beat while no session is open, skips the
// divider. tready returns at the edge that loads the result register, so
// the next beat can be accepted from then on. The input takes the next beat
// while an earlier result still waits for the output side; a waiting result
// holds the sequencer only in its load step. Configuration is written through
// a plain write port; the user must write it only while the block is idle,
// which the block itself leaves unenforced. Writes take effect at once.
module speech_endpoint_detector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Stream input: one block summary or begin request per beat.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, low to high: block_samples[12:0], peak_level[28:13],
  // avg_level[44:29], stop_requested[45], read_failed[46], zero pad[47].
  input  logic [sed_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // tuser: kind (0 audio block summary, 1 begin new session).
  input  logic                               s_axis_tuser,
  // Stream output: one result per input beat.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, low to high: smooth_level[15:0], elapsed_seconds[36:16],
  // progress_event[37], kept_start[58:38], kept_count[79:59].
  output logic [sed_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // tuser: outcome.
  output logic [sed_pkg::OUTCOME_BITS-1:0]   m_axis_tuser,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [sed_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [sed_pkg::COUNT_BITS-1:0]     cfg_data_i
);
  import sed_pkg::*;

  localparam logic [COUNT_BITS-1:0] RST_CAP_LIMIT   = COUNT_BITS'(480000);
  localparam logic [COUNT_BITS-1:0] RST_TIMEOUT     = COUNT_BITS'(96000);
  localparam logic [COUNT_BITS-1:0] RST_CONFIRM     = COUNT_BITS'(1280);
  localparam logic [COUNT_BITS-1:0] RST_SILENCE     = COUNT_BITS'(19200);
  localparam logic [COUNT_BITS-1:0] RST_PREROLL     = COUNT_BITS'(4800);
  localparam logic [RATE_BITS-1:0]  RST_RATE        = RATE_BITS'(16000);
  localparam logic [LEVEL_BITS-1:0] RST_START_LEVEL = LEVEL_BITS'(55);
  localparam logic [LEVEL_BITS-1:0] RST_MARGIN      = LEVEL_BITS'(15);

  localparam int ST_BITS = 4;
  localparam logic [ST_BITS-1:0] ST_IDLE   = 4'd0;
  localparam logic [ST_BITS-1:0] ST_SAT    = 4'd1;
  localparam logic [ST_BITS-1:0] ST_ACC    = 4'd2;
  localparam logic [ST_BITS-1:0] ST_CLAMP  = 4'd3;
  localparam logic [ST_BITS-1:0] ST_DECIDE = 4'd4;
  localparam logic [ST_BITS-1:0] ST_TRIM   = 4'd5;
  localparam logic [ST_BITS-1:0] ST_PAY    = 4'd6;
  localparam logic [ST_BITS-1:0] ST_DIVGO  = 4'd7;
  localparam logic [ST_BITS-1:0] ST_DIV    = 4'd8;
  localparam logic [ST_BITS-1:0] ST_EMIT   = 4'd9;

  // Configuration registers.
  logic [COUNT_BITS-1:0] max_q, timeout_q, confirm_q, silence_cfg_q, preroll_q;
  logic [RATE_BITS-1:0]  rate_q;
  logic [LEVEL_BITS-1:0] start_q, margin_q;

  // Sequencer and session state.
  logic [ST_BITS-1:0]    state_q, state_d;
  logic                  active_q, active_d;
  logic [COUNT_BITS-1:0] cap_q, cap_d;
  logic [COUNT_BITS-1:0] voiced_q, voiced_d;
  logic [COUNT_BITS-1:0] silence_q, silence_d;
  logic [COUNT_BITS-1:0] begin_q, begin_d;
  logic                  found_q, found_d;
  logic [LEVEL_BITS-1:0] lvl_q, lvl_d;
  logic [LEVEL_BITS-1:0] idle_q, idle_d;
  logic [COUNT_BITS-1:0] last_q, last_d;
  logic                  reported_q, reported_d;

  // Captured beat and working results.
  logic                  kind_q, kind_d;
  logic [BLOCK_BITS-1:0] bcnt_q, bcnt_d;
  logic [LEVEL_BITS-1:0] peak_q, peak_d;
  logic [LEVEL_BITS-1:0] mean_q, mean_d;
  logic                  stop_q, stop_d;
  logic                  fail_q, fail_d;
  outcome_e              outcome_q, outcome_d;
  logic [COUNT_BITS-1:0] trim_q, trim_d;
  logic [COUNT_BITS-1:0] pay_q, pay_d;
  logic                  prog_en_q, prog_en_d;
  logic                  fin_q, fin_d;
  logic                  zero_el_q, zero_el_d;

  // Result register.
  logic                  m_valid_q, m_valid_d;
  outcome_e              o_outcome_q, o_outcome_d;
  logic [LEVEL_BITS-1:0] o_level_q, o_level_d;
  logic [COUNT_BITS-1:0] o_secs_q, o_secs_d;
  logic                  o_prog_q, o_prog_d;
  logic [COUNT_BITS-1:0] o_trim_q, o_trim_d;
  logic [COUNT_BITS-1:0] o_pay_q, o_pay_d;

  // Datapath terms.
  logic                  in_accept;
  logic [BLOCK_BITS-1:0] cnt_lim;
  logic [COUNT_BITS-1:0] room;
  logic [COUNT_BITS-1:0] cnt_lim_ext;
  logic [COUNT_BITS-1:0] cnt_sat;
  logic [COUNT_BITS-1:0] cnt_ext;
  logic [LEVEL_BITS+1:0] lvl_up;
  logic [LEVEL_BITS+2:0] lvl_dn;
  logic [LEVEL_BITS-1:0] lvl_new;
  logic [LEVEL_BITS:0]   thr_sum;
  logic [THR_BITS-1:0]   thr;
  logic                  quiet;
  logic [COUNT_BITS-1:0] voiced_sum;
  logic [COUNT_BITS-1:0] silence_sum;
  logic [COUNT_BITS-1:0] begin_diff;
  logic [COUNT_BITS-1:0] trim_val;
  logic [COUNT_BITS-1:0] pay_val;
  logic [COUNT_BITS-1:0] secs;
  logic                  progress;

  // Divider handshake.
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [COUNT_BITS-1:0] div_quo;

  sed_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cap_q),
    .divisor_i  (rate_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // The block count is first held to the largest block, then to the room left.
  assign cnt_lim     = (bcnt_q > BLOCK_BITS'(MAX_BLOCK)) ? BLOCK_BITS'(MAX_BLOCK) : bcnt_q;
  assign room        = max_q - cap_q;
  assign cnt_lim_ext = COUNT_BITS'(cnt_lim);
  assign cnt_sat     = (cnt_lim_ext > room) ? room : cnt_lim_ext;
  assign cnt_ext     = COUNT_BITS'(bcnt_q);

  // Rising level: (level + 3 * peak) / 4. Falling level: (7 * level + peak) / 8.
  assign lvl_up  = {2'b00, lvl_q} + {1'b0, peak_q, 1'b0} + {2'b00, peak_q};
  assign lvl_dn  = {lvl_q, 3'b000} - {3'b000, lvl_q} + {3'b000, peak_q};
  assign lvl_new = (peak_q > lvl_q) ? lvl_up[LEVEL_BITS+1:2] : lvl_dn[LEVEL_BITS+2:3];

  // The silence threshold is formed one bit wider so it cannot wrap, then clamped.
  assign thr_sum = {1'b0, idle_q} + {1'b0, margin_q};
  assign thr     = (thr_sum < (LEVEL_BITS+1)'(SIL_FLOOR)) ? THR_BITS'(SIL_FLOOR) :
                   (thr_sum > (LEVEL_BITS+1)'(SIL_CEIL))  ? THR_BITS'(SIL_CEIL)  :
                   thr_sum[THR_BITS-1:0];
  assign quiet   = (mean_q <= LEVEL_BITS'(thr));

  assign voiced_sum  = voiced_q + cnt_ext;
  assign silence_sum = silence_q + cnt_ext;
  assign begin_diff  = cap_q - voiced_q;
  assign trim_val    = (begin_q > preroll_q) ? (begin_q - preroll_q) : '0;
  assign pay_val     = cap_q - trim_q;

  assign secs     = zero_el_q ? '0 : div_quo;
  assign progress = prog_en_q && (!reported_q || (secs != last_q));

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    cap_d       = cap_q;
    voiced_d    = voiced_q;
    silence_d   = silence_q;
    begin_d     = begin_q;
    found_d     = found_q;
    lvl_d       = lvl_q;
    idle_d      = idle_q;
    last_d      = last_q;
    reported_d  = reported_q;
    kind_d      = kind_q;
    bcnt_d      = bcnt_q;
    peak_d      = peak_q;
    mean_d      = mean_q;
    stop_d      = stop_q;
    fail_d      = fail_q;
    outcome_d   = outcome_q;
    trim_d      = trim_q;
    pay_d       = pay_q;
    prog_en_d   = prog_en_q;
    fin_d       = fin_q;
    zero_el_d   = zero_el_q;
    o_outcome_d = o_outcome_q;
    o_level_d   = o_level_q;
    o_secs_d    = o_secs_q;
    o_prog_d    = o_prog_q;
    o_trim_d    = o_trim_q;
    o_pay_d     = o_pay_q;
    div_start   = 1'b0;
    m_valid_d   = (m_valid_q && m_axis_tready) ? 1'b0 : m_valid_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          kind_d  = s_axis_tuser;
          bcnt_d  = s_axis_tdata[12:0];
          peak_d  = s_axis_tdata[28:13];
          mean_d  = s_axis_tdata[44:29];
          stop_d  = s_axis_tdata[45];
          fail_d  = s_axis_tdata[46];
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        outcome_d = OUT_CONTINUE;
        trim_d    = '0;
        pay_d     = '0;
        prog_en_d = 1'b0;
        fin_d     = 1'b0;
        zero_el_d = 1'b0;
        if (kind_q) begin
          // Begin: clear the session and open a new one.
          active_d   = 1'b1;
          cap_d      = '0;
          voiced_d   = '0;
          silence_d  = '0;
          begin_d    = '0;
          found_d    = 1'b0;
          lvl_d      = '0;
          idle_d     = '0;
          last_d     = '0;
          reported_d = 1'b0;
          outcome_d  = OUT_IDLE;
          zero_el_d  = 1'b1;
          state_d    = ST_EMIT;
        end else if (!active_q) begin
          outcome_d = OUT_IDLE;
          zero_el_d = 1'b1;
          state_d   = ST_EMIT;
        end else if (fail_q) begin
          active_d  = 1'b0;
          outcome_d = OUT_READ_ERROR;
          state_d   = ST_DIVGO;
        end else if (cap_q >= max_q) begin
          // The limit was lowered under a running session: end it now.
          fin_d   = 1'b1;
          state_d = ST_TRIM;
        end else if (bcnt_q != '0) begin
          bcnt_d    = BLOCK_BITS'(cnt_sat);
          prog_en_d = 1'b1;
          state_d   = ST_ACC;
        end else begin
          // An empty block is ignored, stop request included.
          state_d = ST_DIVGO;
        end
      end
      ST_ACC: begin
        cap_d = cap_q + cnt_ext;
        lvl_d = lvl_new;
        if (!found_q) begin
          if ((idle_q == '0) || (mean_q < idle_q)) begin
            idle_d = mean_q;
          end
          voiced_d = (peak_q >= start_q) ? voiced_sum : '0;
        end else begin
          silence_d = quiet ? silence_sum : '0;
        end
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (!found_q && (voiced_q > cap_q)) begin
          voiced_d = cap_q;
        end
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        fin_d   = stop_q || (cap_q >= max_q);
        state_d = ST_TRIM;
        if (!found_q) begin
          if (voiced_q >= confirm_q) begin
            found_d   = 1'b1;
            silence_d = '0;
            begin_d   = begin_diff;
          end else if (cap_q >= timeout_q) begin
            active_d  = 1'b0;
            outcome_d = OUT_NO_SPEECH;
            state_d   = ST_DIVGO;
          end
        end else if (silence_q >= silence_cfg_q) begin
          fin_d = 1'b1;
        end
      end
      ST_TRIM: begin
        if (fin_q) begin
          active_d = 1'b0;
          if (found_q) begin
            outcome_d = OUT_CAPTURED;
            trim_d    = trim_val;
          end else begin
            outcome_d = OUT_NO_SPEECH;
          end
        end
        state_d = ST_PAY;
      end
      ST_PAY: begin
        if (outcome_q == OUT_CAPTURED) begin
          pay_d = pay_val;
        end
        state_d = ST_DIVGO;
      end
      ST_DIVGO: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d   = 1'b1;
          o_outcome_d = outcome_q;
          o_level_d   = lvl_q;
          o_secs_d    = secs;
          o_prog_d    = progress;
          o_trim_d    = trim_q;
          o_pay_d     = pay_q;
          if (progress) begin
            last_d     = secs;
            reported_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q         <= RST_CAP_LIMIT;
      timeout_q     <= RST_TIMEOUT;
      confirm_q     <= RST_CONFIRM;
      silence_cfg_q <= RST_SILENCE;
      preroll_q     <= RST_PREROLL;
      rate_q        <= RST_RATE;
      start_q       <= RST_START_LEVEL;
      margin_q      <= RST_MARGIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAP_LIMIT:       max_q         <= cfg_data_i;
        CFG_START_TIMEOUT:   timeout_q     <= cfg_data_i;
        CFG_CONFIRM_SAMPLES: confirm_q     <= cfg_data_i;
        CFG_SILENCE_SAMPLES: silence_cfg_q <= cfg_data_i;
        CFG_PREROLL_SAMPLES: preroll_q     <= cfg_data_i;
        CFG_RATE_HZ:         rate_q        <= cfg_data_i[RATE_BITS-1:0];
        CFG_START_LEVEL:     start_q       <= cfg_data_i[LEVEL_BITS-1:0];
        CFG_SILENCE_MARGIN:  margin_q      <= cfg_data_i[LEVEL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      active_q   <= 1'b0;
      cap_q      <= '0;
      voiced_q   <= '0;
      silence_q  <= '0;
      begin_q    <= '0;
      found_q    <= 1'b0;
      lvl_q      <= '0;
      idle_q     <= '0;
      last_q     <= '0;
      reported_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      cap_q      <= cap_d;
      voiced_q   <= voiced_d;
      silence_q  <= silence_d;
      begin_q    <= begin_d;
      found_q    <= found_d;
      lvl_q      <= lvl_d;
      idle_q     <= idle_d;
      last_q     <= last_d;
      reported_q <= reported_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    bcnt_q      <= bcnt_d;
    peak_q      <= peak_d;
    mean_q      <= mean_d;
    stop_q      <= stop_d;
    fail_q      <= fail_d;
    outcome_q   <= outcome_d;
    trim_q      <= trim_d;
    pay_q       <= pay_d;
    prog_en_q   <= prog_en_d;
    fin_q       <= fin_d;
    zero_el_q   <= zero_el_d;
    o_outcome_q <= o_outcome_d;
    o_level_q   <= o_level_d;
    o_secs_q    <= o_secs_d;
    o_prog_q    <= o_prog_d;
    o_trim_q    <= o_trim_d;
    o_pay_q     <= o_pay_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = o_outcome_q;
  assign m_axis_tdata  = {o_pay_q, o_trim_q, o_prog_q, o_secs_q, o_level_q};

  // A new result only ever comes out of the load step.
  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside the load step");

  // The shared divider is never restarted while it is still iterating.
  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // An accepted beat always enters the saturation step next.
  a_accept_to_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_SAT))
    else $error("accepted beat not processed");

  // Trim and payload are only nonzero on a captured outcome.
  a_trim_only_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (o_outcome_q != OUT_CAPTURED)) |-> ((o_trim_q == '0) && (o_pay_q == '0)))
    else $error("kept region reported without a capture");

endmodule
